[hw/rtl/erle_pkg.sv]
`timescale 1ns / 1ps

package erle_pkg;

  localparam logic [7:0] ESC_BYTE = 8'h81;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_PAD   = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_BETWEEN  = 2'd1;
  localparam logic [1:0] MODE_ENCODING = 2'd2;

  localparam logic REG_SOURCE_ROW_BYTES = 1'b0;
  localparam logic REG_SOURCE_ROWS      = 1'b1;

  localparam logic [13:0] ROW_BYTES_RESET = 14'd80;
  localparam logic [15:0] ROWS_RESET      = 16'd400;
  localparam logic [13:0] ROW_BYTES_MAX   = 14'd8192;
  localparam logic [15:0] ROW_COUNT_MAX   = 16'hffff;
  localparam logic [6:0]  EXTRA_MAX       = 7'd127;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } src_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_burst;
    logic       image_done;
  } enc_item_t;

  // One token expands to one to three bytes: an escape sequence
  // (0x81, extra, value, or the two-byte header) or literal copies.
  typedef struct packed {
    logic       esc;
    logic [1:0] len;
    logic [6:0] extra;
    logic [7:0] value;
  } token_t;

  typedef struct packed {
    token_t [2:0] tok;
    logic [1:0]   ntok;
    logic         done;
  } entry_t;

  function automatic token_t run_token(input logic [7:0] value, input logic [6:0] extra);
    token_t t;
    t.value = value;
    t.extra = extra;
    if (extra >= 7'd2 || value == ESC_BYTE) begin
      t.esc = 1'b1;
      t.len = 2'd3;
    end else begin
      t.esc = 1'b0;
      t.len = extra[0] ? 2'd2 : 2'd1;
    end
    return t;
  endfunction

  function automatic token_t pad_token(input logic [6:0] extra);
    token_t t;
    t.esc   = 1'b1;
    t.len   = 2'd3;
    t.extra = extra;
    t.value = 8'h00;
    return t;
  endfunction

  function automatic token_t header_token();
    token_t t;
    t.esc   = 1'b1;
    t.len   = 2'd2;
    t.extra = 7'd0;
    t.value = 8'h00;
    return t;
  endfunction

endpackage

[hw/rtl/erle_front.sv]
`timescale 1ns / 1ps

module erle_front #(
  parameter int DEST_ROW_BYTES = 80,
  parameter int DEST_ROWS      = 400,
  parameter int DW             = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  erle_pkg::src_item_t src_item,
  input  logic [13:0]         row_bytes,
  input  logic [15:0]         rows,
  output logic                push,
  output erle_pkg::entry_t    push_entry,
  input  logic                full
);

  logic [1:0]    coding_mode, coding_mode_next;
  logic [7:0]    run_value, run_value_next;
  logic [6:0]    run_extra, run_extra_next;
  logic [12:0]   column_count, column_count_next;
  logic [15:0]   source_row_count, source_row_count_next;
  logic [DW-1:0] dest_row_count, dest_row_count_next;

  logic          accept;
  logic [13:0]   sw;
  logic [13:0]   minw;
  logic [13:0]   col_inc;
  logic [1:0]    mode_eff;
  logic [1:0]    n;
  erle_pkg::entry_t entry;

  assign src_stall = full;
  assign accept    = src_valid && !full;

  always_comb begin
    if (row_bytes == 14'd0) begin
      sw = 14'd1;
    end else if (row_bytes > erle_pkg::ROW_BYTES_MAX) begin
      sw = erle_pkg::ROW_BYTES_MAX;
    end else begin
      sw = row_bytes;
    end
    minw    = (sw < 14'(DEST_ROW_BYTES)) ? sw : 14'(DEST_ROW_BYTES);
    col_inc = {1'b0, column_count} + 14'd1;
  end

  always_comb begin
    coding_mode_next      = coding_mode;
    run_value_next        = run_value;
    run_extra_next        = run_extra;
    column_count_next     = column_count;
    source_row_count_next = source_row_count;
    dest_row_count_next   = dest_row_count;
    mode_eff              = coding_mode;
    n                     = 2'd0;
    entry                 = '0;
    unique case (src_item.command)
      erle_pkg::CMD_START: begin
        entry.tok[0]          = erle_pkg::header_token();
        n                     = 2'd1;
        run_value_next        = 8'h00;
        run_extra_next        = 7'd0;
        column_count_next     = 13'd0;
        source_row_count_next = 16'd0;
        dest_row_count_next   = '0;
        coding_mode_next      = erle_pkg::MODE_BETWEEN;
      end
      erle_pkg::CMD_DATA: begin
        if (coding_mode != erle_pkg::MODE_IDLE && source_row_count < rows) begin
          if (column_count == 13'd0) begin
            mode_eff = (dest_row_count < DW'(DEST_ROWS)) ? erle_pkg::MODE_ENCODING
                                                         : erle_pkg::MODE_BETWEEN;
          end
          coding_mode_next = mode_eff;
          if (mode_eff == erle_pkg::MODE_ENCODING) begin
            if (column_count == 13'd0) begin
              run_value_next = src_item.data_byte;
              run_extra_next = 7'd0;
            end else if (src_item.data_byte == run_value &&
                         run_extra != erle_pkg::EXTRA_MAX) begin
              run_extra_next = run_extra + 7'd1;
            end else begin
              entry.tok[n]   = erle_pkg::run_token(run_value, run_extra);
              n              = n + 2'd1;
              run_value_next = src_item.data_byte;
              run_extra_next = 7'd0;
            end
            if (col_inc >= minw) begin
              entry.tok[n] = erle_pkg::run_token(run_value_next, run_extra_next);
              n            = n + 2'd1;
              if (sw < 14'(DEST_ROW_BYTES)) begin
                entry.tok[n] = erle_pkg::pad_token(
                  7'(14'(DEST_ROW_BYTES) - sw - 14'd1));
                n = n + 2'd1;
              end
              dest_row_count_next = dest_row_count + DW'(1);
              entry.done          = (dest_row_count_next == DW'(DEST_ROWS));
              coding_mode_next    = erle_pkg::MODE_BETWEEN;
            end
          end
          if (col_inc >= sw) begin
            column_count_next = 13'd0;
            if (source_row_count != erle_pkg::ROW_COUNT_MAX) begin
              source_row_count_next = source_row_count + 16'd1;
            end
          end else begin
            column_count_next = col_inc[12:0];
          end
        end
      end
      erle_pkg::CMD_PAD: begin
        if (coding_mode == erle_pkg::MODE_BETWEEN && column_count == 13'd0 &&
            dest_row_count < DW'(DEST_ROWS)) begin
          entry.tok[0]        = erle_pkg::pad_token(7'(DEST_ROW_BYTES - 1));
          n                   = 2'd1;
          dest_row_count_next = dest_row_count + DW'(1);
          entry.done          = (dest_row_count_next == DW'(DEST_ROWS));
        end
      end
      erle_pkg::CMD_NONE: begin
      end
      default: begin
      end
    endcase
    entry.ntok = n;
  end

  assign push       = accept && (n != 2'd0);
  assign push_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode      <= erle_pkg::MODE_IDLE;
      run_value        <= 8'h00;
      run_extra        <= 7'd0;
      column_count     <= 13'd0;
      source_row_count <= 16'd0;
      dest_row_count   <= '0;
    end else if (accept) begin
      coding_mode      <= coding_mode_next;
      run_value        <= run_value_next;
      run_extra        <= run_extra_next;
      column_count     <= column_count_next;
      source_row_count <= source_row_count_next;
      dest_row_count   <= dest_row_count_next;
    end
  end

endmodule

[hw/rtl/erle_queue.sv]
`timescale 1ns / 1ps

module erle_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  erle_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output erle_pkg::entry_t head
);

  localparam int AW = $clog2(erle_pkg::QUEUE_DEPTH);

  erle_pkg::entry_t mem [erle_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign full  = (count == (AW + 1)'(erle_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

endmodule

[hw/rtl/erle_back.sv]
`timescale 1ns / 1ps

module erle_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  erle_pkg::entry_t    head,
  output logic                pop,
  output logic                enc_valid,
  input  logic                enc_stall,
  output erle_pkg::enc_item_t enc_item
);

  logic [1:0]        slot;
  logic [1:0]        kidx;
  erle_pkg::token_t  tok;
  logic [7:0]        cur_byte;
  logic              last_tok;
  logic              last_item;
  logic              load;

  assign tok       = head.tok[slot];
  assign last_tok  = (kidx == tok.len - 2'd1);
  assign last_item = last_tok && (slot == head.ntok - 2'd1);
  assign load      = !empty && (!enc_valid || !enc_stall);
  assign pop       = load && last_item;

  always_comb begin
    cur_byte = tok.value;
    if (tok.esc) begin
      unique case (kidx)
        2'd0:    cur_byte = erle_pkg::ESC_BYTE;
        2'd1:    cur_byte = {1'b0, tok.extra};
        default: cur_byte = tok.value;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= 2'd0;
      kidx      <= 2'd0;
      enc_valid <= 1'b0;
    end else begin
      if (load) begin
        enc_valid <= 1'b1;
        if (last_tok) begin
          kidx <= 2'd0;
          slot <= last_item ? 2'd0 : slot + 2'd1;
        end else begin
          kidx <= kidx + 2'd1;
        end
      end else if (!enc_stall) begin
        enc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      enc_item.out_byte      <= cur_byte;
      enc_item.last_of_burst <= last_item;
      enc_item.image_done    <= last_item && head.done;
    end
  end

endmodule

[hw/rtl/escape_rle_mono_row_encoder.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// src       in         src_valid/src_stall   erle_pkg::src_item_t
// enc       out        enc_valid/enc_stall   erle_pkg::enc_item_t
// apb       in         psel/penable/pready   two 32-bit registers
//
// One source item is taken each cycle while the four-entry token queue has room.
// An item turns into zero to nine bytes, which leave at one byte a cycle unless
// the output stalls, so the byte output stage sets the sustained rate. Reset is
// synchronous and leaves both channels empty with the encoder idle until a start
// command. A stall on the output backs up the queue before it stalls the source.
module escape_rle_mono_row_encoder #(
  parameter int DEST_ROW_BYTES = 80,
  parameter int DEST_ROWS      = 400
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  erle_pkg::src_item_t src_item,
  output logic                enc_valid,
  input  logic                enc_stall,
  output erle_pkg::enc_item_t enc_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int DW = $clog2(DEST_ROWS + 1);

  logic [13:0]      row_bytes;
  logic [15:0]      rows;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  erle_pkg::entry_t push_entry;
  erle_pkg::entry_t head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= erle_pkg::ROW_BYTES_RESET;
      rows      <= erle_pkg::ROWS_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == erle_pkg::REG_SOURCE_ROW_BYTES) begin
        row_bytes <= pwdata[13:0];
      end else begin
        rows <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == erle_pkg::REG_SOURCE_ROW_BYTES) begin
      prdata = {18'd0, row_bytes};
    end else begin
      prdata = {16'd0, rows};
    end
  end

  erle_front #(
    .DEST_ROW_BYTES(DEST_ROW_BYTES),
    .DEST_ROWS     (DEST_ROWS),
    .DW            (DW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .row_bytes (row_bytes),
    .rows      (rows),
    .push      (push),
    .push_entry(push_entry),
    .full      (full)
  );

  erle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  erle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .enc_valid(enc_valid),
    .enc_stall(enc_stall),
    .enc_item (enc_item)
  );

endmodule

[hw/rtl/erle_checker.sv]
`timescale 1ns / 1ps

module erle_checker (
  input logic                clk,
  input logic                rst,
  input logic                enc_valid,
  input logic                enc_stall,
  input erle_pkg::enc_item_t enc_item
);

  // A stalled output item stays offered unchanged.
  a_enc_hold: assert property (@(posedge clk) disable iff (rst)
    enc_valid && enc_stall |=> enc_valid && $stable(enc_item))
    else $error("output item changed while stalled");

  // The end of the image is flagged only on the final byte of an item.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    enc_valid |-> (!enc_item.image_done || enc_item.last_of_burst))
    else $error("image_done without last_of_burst");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !enc_valid)
    else $error("output valid after reset");

endmodule

bind escape_rle_mono_row_encoder erle_checker u_erle_checker (
  .clk      (clk),
  .rst      (rst),
  .enc_valid(enc_valid),
  .enc_stall(enc_stall),
  .enc_item (enc_item)
);

[bench/escape_rle_mono_row_encoder_tb.sv]
`timescale 1ns / 1ps

module escape_rle_mono_row_encoder_tb;

  localparam int DEST_ROW_BYTES = 80;
  localparam int DEST_ROWS      = 400;
  localparam int SETTLE_CYCLES  = 20;
  localparam int CYCLE_LIMIT    = 1000000;

  // Tracks the encoder's image, row and run state and holds the encoded
  // bytes that are still to come out, in order.
  class byte_stream_board;
    logic [13:0]         row_bytes_reg;
    logic [15:0]         rows_reg;
    logic [1:0]          mode;
    logic [7:0]          run_val;
    int                  run_extra_cnt;
    int                  column;
    int                  src_rows_seen;
    int                  dst_rows_done;
    erle_pkg::enc_item_t burst[$];
    erle_pkg::enc_item_t awaited[$];
    int                  errors;

    function new();
      errors        = 0;
      row_bytes_reg = erle_pkg::ROW_BYTES_RESET;
      rows_reg      = erle_pkg::ROWS_RESET;
      mode          = erle_pkg::MODE_IDLE;
      run_val       = 8'h00;
      run_extra_cnt = 0;
      column        = 0;
      src_rows_seen = 0;
      dst_rows_done = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == erle_pkg::REG_SOURCE_ROW_BYTES) begin
        row_bytes_reg = value[13:0];
      end else begin
        rows_reg = value[15:0];
      end
    endfunction

    function void put_byte(logic [7:0] b);
      erle_pkg::enc_item_t e;
      e.out_byte      = b;
      e.last_of_burst = 1'b0;
      e.image_done    = 1'b0;
      burst.push_back(e);
    endfunction

    function void close_run();
      if (run_extra_cnt >= 2 || run_val == erle_pkg::ESC_BYTE) begin
        put_byte(erle_pkg::ESC_BYTE);
        put_byte(8'(run_extra_cnt));
        put_byte(run_val);
      end else begin
        for (int i = 0; i <= run_extra_cnt; i++) put_byte(run_val);
      end
    endfunction

    function void row_done();
      erle_pkg::enc_item_t e;
      if (dst_rows_done < DEST_ROWS) dst_rows_done++;
      if (dst_rows_done == DEST_ROWS && burst.size() > 0) begin
        e = burst.pop_back();
        e.image_done = 1'b1;
        burst.push_back(e);
      end
    endfunction

    function void take_data(logic [7:0] b);
      int sw;
      int minw;
      int col;
      sw = row_bytes_reg;
      if (sw == 0) sw = 1;
      if (sw > int'(erle_pkg::ROW_BYTES_MAX)) sw = int'(erle_pkg::ROW_BYTES_MAX);
      minw = (sw < DEST_ROW_BYTES) ? sw : DEST_ROW_BYTES;
      if (src_rows_seen >= int'(rows_reg)) return;
      col = column;
      if (col == 0) mode = (dst_rows_done < DEST_ROWS) ? erle_pkg::MODE_ENCODING
                                                       : erle_pkg::MODE_BETWEEN;
      if (mode == erle_pkg::MODE_ENCODING) begin
        if (col == 0) begin
          run_val       = b;
          run_extra_cnt = 0;
        end else if (b == run_val && run_extra_cnt < int'(erle_pkg::EXTRA_MAX)) begin
          run_extra_cnt++;
        end else begin
          close_run();
          run_val       = b;
          run_extra_cnt = 0;
        end
        if (col + 1 >= minw) begin
          close_run();
          if (sw < DEST_ROW_BYTES) begin
            put_byte(erle_pkg::ESC_BYTE);
            put_byte(8'(DEST_ROW_BYTES - sw - 1));
            put_byte(8'h00);
          end
          row_done();
          mode = erle_pkg::MODE_BETWEEN;
        end
      end
      col++;
      if (col >= sw) begin
        col = 0;
        if (src_rows_seen < int'(erle_pkg::ROW_COUNT_MAX)) src_rows_seen++;
      end
      column = col & 16'h1fff;
    endfunction

    function void take_source(erle_pkg::src_item_t it);
      erle_pkg::enc_item_t e;
      burst.delete();
      case (it.command)
        erle_pkg::CMD_START: begin
          put_byte(erle_pkg::ESC_BYTE);
          put_byte(8'h00);
          run_val       = 8'h00;
          run_extra_cnt = 0;
          column        = 0;
          src_rows_seen = 0;
          dst_rows_done = 0;
          mode          = erle_pkg::MODE_BETWEEN;
        end
        erle_pkg::CMD_DATA: begin
          if (mode != erle_pkg::MODE_IDLE) take_data(it.data_byte);
        end
        erle_pkg::CMD_PAD: begin
          if (mode == erle_pkg::MODE_BETWEEN && column == 0 &&
              dst_rows_done < DEST_ROWS) begin
            put_byte(erle_pkg::ESC_BYTE);
            put_byte(8'(DEST_ROW_BYTES - 1));
            put_byte(8'h00);
            row_done();
          end
        end
        default: begin
        end
      endcase
      if (burst.size() > 0) begin
        e = burst.pop_back();
        e.last_of_burst = 1'b1;
        burst.push_back(e);
      end
      foreach (burst[i]) awaited.push_back(burst[i]);
    endfunction

    task report(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endtask

    task match_byte(erle_pkg::enc_item_t got);
      erle_pkg::enc_item_t want;
      if (awaited.size() == 0) begin
        report($sformatf("byte %02h arrived with nothing outstanding", got.out_byte));
      end else begin
        want = awaited.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte %02h, wanted %02h", got.out_byte, want.out_byte));
        if (got.last_of_burst !== want.last_of_burst)
          report($sformatf("last_of_burst %b, wanted %b on byte %02h",
                           got.last_of_burst, want.last_of_burst, want.out_byte));
        if (got.image_done !== want.image_done)
          report($sformatf("image_done %b, wanted %b on byte %02h",
                           got.image_done, want.image_done, want.out_byte));
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                src_valid;
  logic                src_stall;
  erle_pkg::src_item_t src_item;
  logic                enc_valid;
  logic                enc_stall;
  erle_pkg::enc_item_t enc_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  byte_stream_board    board = new();
  erle_pkg::enc_item_t seen_byte;
  int                  cycle_count;
  int                  stall_left;
  bit                  feed_gaps;
  bit                  drain_stalls;

  escape_rle_mono_row_encoder #(
    .DEST_ROW_BYTES(DEST_ROW_BYTES),
    .DEST_ROWS(DEST_ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_item(src_item),
    .enc_valid(enc_valid),
    .enc_stall(enc_stall),
    .enc_item(enc_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 30);
  endfunction

  initial begin
    enc_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        enc_stall = 1'b1;
        stall_left--;
      end else begin
        enc_stall = 1'b0;
        if (drain_stalls) stall_left = pick_idle();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && enc_valid && !enc_stall) begin
      seen_byte = enc_item;
      #1 board.match_byte(seen_byte);
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [7:0] val);
    erle_pkg::src_item_t it;
    int                  gap;
    it.command   = cmd;
    it.data_byte = val;
    gap = feed_gaps ? pick_idle() : 0;
    if (gap > 0) begin
      @(negedge clk);
      src_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    src_valid = 1'b1;
    src_item  = it;
    do @(posedge clk); while (src_stall);
    board.take_source(it);
  endtask

  task automatic wait_empty();
    @(negedge clk);
    src_valid = 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_set(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value)
      board.report($sformatf("register %0d reads %0h, wrote %0h", idx, prdata, value));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_format(input int row_bytes, input int rows);
    reg_set(erle_pkg::REG_SOURCE_ROW_BYTES, 32'(row_bytes));
    reg_set(erle_pkg::REG_SOURCE_ROWS, 32'(rows));
  endtask

  function automatic logic [7:0] next_pixels(input logic [7:0] prev);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return prev;
    if (r < 55) return erle_pkg::ESC_BYTE;
    if (r < 62) return 8'h00;
    if (r < 68) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_phase(input int row_bytes, input int rows, input bit fresh,
                              input int count, input bit allow_start);
    logic [7:0] px;
    logic [1:0] cmd;
    int         r;
    settle();
    set_format(row_bytes, rows);
    feed_gaps    = ($urandom_range(0, 3) != 0);
    drain_stalls = ($urandom_range(0, 3) != 0);
    px = 8'($urandom_range(0, 255));
    if (fresh) send_item(erle_pkg::CMD_START, 8'($urandom_range(0, 255)));
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_empty();
      r = $urandom_range(0, 199);
      if (r < 3 && allow_start) cmd = erle_pkg::CMD_START;
      else if (r < 7) cmd = erle_pkg::CMD_NONE;
      else if (r < 21) cmd = erle_pkg::CMD_PAD;
      else cmd = erle_pkg::CMD_DATA;
      if (cmd == erle_pkg::CMD_DATA) begin
        px = next_pixels(px);
        send_item(cmd, px);
      end else begin
        send_item(cmd, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    src_valid    = 1'b0;
    src_item     = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    feed_gaps    = 1'b1;
    drain_stalls = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(erle_pkg::CMD_DATA, 8'h5a);
    send_item(erle_pkg::CMD_PAD, 8'h00);
    send_item(erle_pkg::CMD_NONE, 8'hff);
    send_item(erle_pkg::CMD_START, 8'h00);
    send_item(erle_pkg::CMD_PAD, 8'h00);
    send_item(erle_pkg::CMD_NONE, 8'h00);

    settle();
    set_format(6, 2);
    send_item(erle_pkg::CMD_START, 8'hff);
    send_item(erle_pkg::CMD_DATA, erle_pkg::ESC_BYTE);
    send_item(erle_pkg::CMD_DATA, 8'h00);
    send_item(erle_pkg::CMD_DATA, 8'h00);
    send_item(erle_pkg::CMD_DATA, 8'hff);
    send_item(erle_pkg::CMD_DATA, 8'hff);
    send_item(erle_pkg::CMD_DATA, 8'hff);
    send_item(erle_pkg::CMD_DATA, erle_pkg::ESC_BYTE);
    send_item(erle_pkg::CMD_DATA, erle_pkg::ESC_BYTE);
    send_item(erle_pkg::CMD_PAD, 8'h00);
    send_item(erle_pkg::CMD_DATA, 8'h00);
    send_item(erle_pkg::CMD_DATA, 8'h7e);
    send_item(erle_pkg::CMD_DATA, 8'h7e);
    send_item(erle_pkg::CMD_DATA, 8'h7e);
    send_item(erle_pkg::CMD_DATA, 8'h33);
    send_item(erle_pkg::CMD_PAD, 8'h00);
    send_item(erle_pkg::CMD_DATA, 8'h10);
    send_item(erle_pkg::CMD_START, 8'h00);
    send_item(erle_pkg::CMD_DATA, 8'h44);
    send_item(erle_pkg::CMD_DATA, 8'h44);
    send_item(erle_pkg::CMD_START, 8'h00);

    random_phase(80, 400, 1'b1, 30, 1'b1);
    random_phase(81, 3, 1'b0, 10, 1'b1);
    random_phase(8192, 65535, 1'b1, 30, 1'b1);
    random_phase(16383, 1, 1'b0, 6, 1'b1);
    random_phase(0, 2, 1'b1, 8, 1'b1);
    random_phase(5, 0, 1'b1, 6, 1'b1);
    random_phase(79, 65535, 1'b1, 15, 1'b1);
    random_phase(1, 65535, 1'b1, 60, 1'b0);

    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
